/* rtl/core/assert_macros.svh */
// Assertion macros used by the checker file of the core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define VBA_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define VBA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/vba_pkg.sv */
// Shared types and constants of the visibility bitmap accumulator.
`default_nettype none

package vba_pkg;

	localparam int unsigned SMP_IDX_W  = 10;
	localparam int unsigned STP_IDX_W  = 8;
	localparam int unsigned STEP_IDX_N = 256;
	localparam int unsigned COMP_W     = 16;
	localparam int unsigned PROD_W     = 2 * COMP_W;
	localparam int unsigned DOT_W      = PROD_W + 1;
	localparam int unsigned CNT_W      = 9;
	localparam int unsigned SCNT_W     = 11;
	localparam int unsigned TCNT_W     = 9;
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 11;

	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_COUNT   = 1'd1;

	localparam logic OP_RECORD = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

	// Control from the sequencer to the store.
	typedef struct packed {
		logic rd;
		logic wr;
		logic clr;
	} vba_mem_ctl_t;

endpackage

`default_nettype wire

/* rtl/core/visibility_bitmap_accumulator_core.sv */
// Visibility bitmap accumulator: lit bits per sample and step, counts and resolved steps.
//
// Request channel (req_valid/req_stall) takes one item: a record (op 0) or a
// query (op 1) of one sample at one step. Response channel (rsp_valid/rsp_stall)
// returns one result per item in order. An item is taken when valid is high and
// stall is low. Config channel (cfg_valid/cfg_ready, always ready) writes
// sample_count (index 0) or step_count (index 1); each write also clears the
// memories and the resolved total. An item passes through the read of the bitmap
// word and count, the dot product that the shared multiplier forms, and, for a
// record, the write-back of the same entries; the result is registered at the
// write-back, and the next item is taken only after it.
// A held result does not block intake: the next item runs until its write-back,
// which waits while rsp_stall holds the previous result.
// After reset and after each config write a clearing pass zeroes the memories;
// req_stall is high during it.
`default_nettype none

module visibility_bitmap_accumulator_core #(
	parameter int unsigned MAX_SAMPLES = 1024,
	parameter int unsigned MAX_STEPS   = 256,
	parameter int unsigned WORD_BITS   = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [vba_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [vba_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                 req_valid,
	output logic                                 req_stall,
	input  logic                                 op,
	input  logic [vba_pkg::SMP_IDX_W-1:0]        sample_index,
	input  logic [vba_pkg::STP_IDX_W-1:0]        step_index,
	input  logic signed [vba_pkg::COMP_W-1:0]    normal_x,
	input  logic signed [vba_pkg::COMP_W-1:0]    normal_y,
	input  logic signed [vba_pkg::COMP_W-1:0]    normal_z,
	input  logic                                 has_normal,
	input  logic signed [vba_pkg::COMP_W-1:0]    sun_x,
	input  logic signed [vba_pkg::COMP_W-1:0]    sun_y,
	input  logic signed [vba_pkg::COMP_W-1:0]    sun_z,
	input  logic                                 blocked,
	input  logic                                 last_of_step,
	output logic                                 rsp_valid,
	input  logic                                 rsp_stall,
	output logic                                 lit,
	output logic [vba_pkg::CNT_W-1:0]            lit_steps,
	output logic                                 step_done,
	output logic [vba_pkg::CNT_W-1:0]            resolved_total,
	output logic                                 error
);
	import vba_pkg::*;

	localparam int unsigned WPS    = (MAX_STEPS + WORD_BITS - 1) / WORD_BITS;
	localparam int unsigned WDEPTH = MAX_SAMPLES * WPS;
	localparam int unsigned WA_W   = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
	localparam int unsigned SA_W   = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
	localparam int unsigned FA_W   = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
	localparam int unsigned BP_W   = $clog2(WORD_BITS);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_BUSY = 1'b1;

	logic                 state_q;
	logic [SCNT_W-1:0]    sample_count_q;
	logic [TCNT_W-1:0]    step_count_q;
	logic [CNT_W-1:0]     tally_q;

	logic                 op_q, has_normal_q, blocked_q, last_q, err_q;
	logic [BP_W-1:0]      bitpos_q;

	logic                 rsp_valid_q;
	logic                 lit_q, step_done_q, error_q;
	logic [CNT_W-1:0]     lit_steps_q, resolved_total_q;

	logic                 req_accept, cfg_write, wb_fire;
	logic                 in_range;
	logic                 dot_busy, dot_facing;
	logic                 clr_busy;
	vba_mem_ctl_t         mem_ctl;

	logic [WA_W-1:0]      quo_tab [STEP_IDX_N];
	logic [BP_W-1:0]      bit_tab [STEP_IDX_N];
	logic [WA_W-1:0]      word_addr;

	logic [WORD_BITS-1:0] word_rdata, word_wdata;
	logic [CNT_W-1:0]     cnt_rdata, cnt_wdata;
	logic                 flag_rdata, flag_wdata;
	logic                 rec, cur, nb, new_lit, new_res;
	logic [CNT_W-1:0]     tally_d;

	// word and bit of each step index, worked out at elaboration
	for (genvar g = 0; g < STEP_IDX_N; g++) begin : g_tab
		localparam int unsigned Q = g / WORD_BITS;
		assign quo_tab[g] = WA_W'(Q);
		assign bit_tab[g] = BP_W'(g - Q * WORD_BITS);
	end

	assign cfg_ready  = 1'b1;
	assign cfg_write  = cfg_valid && cfg_ready;
	assign req_stall  = (state_q != ST_IDLE) || clr_busy;
	assign req_accept = req_valid && !req_stall;

	assign in_range = ({1'b0, sample_index} < sample_count_q)
		&& (32'(sample_index) < MAX_SAMPLES)
		&& ({1'b0, step_index} < step_count_q)
		&& (32'(step_index) < MAX_STEPS);

	assign word_addr = WA_W'(sample_index) * WA_W'(WPS) + quo_tab[step_index];

	assign wb_fire = (state_q == ST_BUSY) && !dot_busy && (!rsp_valid_q || !rsp_stall);

	always_comb begin
		rec     = (op_q == OP_RECORD) && !err_q;
		cur     = word_rdata[bitpos_q];
		nb      = (!has_normal_q || dot_facing) && !blocked_q;
		new_lit = rec ? nb : cur;
		word_wdata           = word_rdata;
		word_wdata[bitpos_q] = nb;
		if (nb && !cur) begin
			cnt_wdata = cnt_rdata + CNT_W'(1);
		end else if (!nb && cur) begin
			cnt_wdata = cnt_rdata - CNT_W'(1);
		end else begin
			cnt_wdata = cnt_rdata;
		end
		new_res    = rec && last_q && !flag_rdata;
		flag_wdata = flag_rdata || (rec && last_q);
		tally_d    = new_res ? tally_q + CNT_W'(1) : tally_q;
		mem_ctl.rd  = req_accept;
		mem_ctl.wr  = wb_fire && rec;
		mem_ctl.clr = cfg_write;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			sample_count_q <= '0;
			step_count_q   <= '0;
			tally_q        <= '0;
			rsp_valid_q    <= 1'b0;
		end else begin
			if (cfg_write) begin
				tally_q <= '0;
				case (cfg_index)
					REG_SAMPLE_COUNT: sample_count_q <= cfg_data;
					REG_STEP_COUNT:   step_count_q   <= cfg_data[TCNT_W-1:0];
					default: ;
				endcase
			end else if (wb_fire) begin
				tally_q <= tally_d;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_accept) begin
						state_q <= ST_BUSY;
					end
				end
				ST_BUSY: begin
					if (wb_fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (wb_fire) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_accept) begin
			op_q         <= op;
			has_normal_q <= has_normal;
			blocked_q    <= blocked;
			last_q       <= last_of_step;
			err_q        <= !in_range;
			bitpos_q     <= bit_tab[step_index];
		end
		if (wb_fire) begin
			error_q          <= err_q;
			resolved_total_q <= tally_d;
			if (err_q) begin
				lit_q       <= 1'b0;
				lit_steps_q <= '0;
				step_done_q <= 1'b0;
			end else begin
				lit_q       <= new_lit;
				lit_steps_q <= rec ? cnt_wdata : cnt_rdata;
				step_done_q <= rec ? flag_wdata : flag_rdata;
			end
		end
	end

	assign rsp_valid      = rsp_valid_q;
	assign lit            = lit_q;
	assign lit_steps      = lit_steps_q;
	assign step_done      = step_done_q;
	assign resolved_total = resolved_total_q;
	assign error          = error_q;

	vba_dot u_dot (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (req_accept),
		.normal_x (normal_x),
		.normal_y (normal_y),
		.normal_z (normal_z),
		.sun_x    (sun_x),
		.sun_y    (sun_y),
		.sun_z    (sun_z),
		.busy     (dot_busy),
		.facing   (dot_facing)
	);

	vba_store #(
		.MAX_SAMPLES (MAX_SAMPLES),
		.MAX_STEPS   (MAX_STEPS),
		.WORD_BITS   (WORD_BITS)
	) u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (mem_ctl),
		.word_addr  (word_addr),
		.cnt_addr   (SA_W'(sample_index)),
		.flag_addr  (FA_W'(step_index)),
		.word_wdata (word_wdata),
		.cnt_wdata  (cnt_wdata),
		.flag_wdata (flag_wdata),
		.word_rdata (word_rdata),
		.cnt_rdata  (cnt_rdata),
		.flag_rdata (flag_rdata),
		.clr_busy   (clr_busy)
	);

endmodule

`default_nettype wire

/* rtl/core/vba_dot.sv */
// Shared multiply-accumulate unit for the normal-sun dot product.
`default_nettype none

module vba_dot (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [vba_pkg::COMP_W-1:0] normal_x,
	input  logic signed [vba_pkg::COMP_W-1:0] normal_y,
	input  logic signed [vba_pkg::COMP_W-1:0] normal_z,
	input  logic signed [vba_pkg::COMP_W-1:0] sun_x,
	input  logic signed [vba_pkg::COMP_W-1:0] sun_y,
	input  logic signed [vba_pkg::COMP_W-1:0] sun_z,
	output logic                              busy,
	output logic                              facing
);
	import vba_pkg::*;

	logic signed [COMP_W-1:0] nx_q, ny_q, nz_q, sx_q, sy_q, sz_q;
	logic signed [COMP_W-1:0] opa, opb;
	logic signed [PROD_W-1:0] prod;
	logic signed [DOT_W-1:0]  acc_q;
	logic [1:0]               k_q;
	logic                     run_q;

	always_comb begin
		case (k_q)
			2'd0: begin
				opa = nx_q;
				opb = sx_q;
			end
			2'd1: begin
				opa = ny_q;
				opb = sy_q;
			end
			default: begin
				opa = nz_q;
				opb = sz_q;
			end
		endcase
		prod = opa * opb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			k_q   <= 2'd0;
		end else if (start) begin
			run_q <= 1'b1;
			k_q   <= 2'd0;
		end else if (run_q) begin
			k_q <= k_q + 2'd1;
			if (k_q == 2'd2) begin
				run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			nx_q  <= normal_x;
			ny_q  <= normal_y;
			nz_q  <= normal_z;
			sx_q  <= sun_x;
			sy_q  <= sun_y;
			sz_q  <= sun_z;
			acc_q <= '0;
		end else if (run_q) begin
			acc_q <= acc_q + DOT_W'(prod);
		end
	end

	assign busy   = run_q;
	// exactly zero faces away
	assign facing = !acc_q[DOT_W-1] && (acc_q != '0);

endmodule

`default_nettype wire

/* rtl/core/vba_store.sv */
// Bitmap, count and resolved-flag memories with their clearing sweep.
`default_nettype none

module vba_store #(
	parameter int unsigned MAX_SAMPLES = 1024,
	parameter int unsigned MAX_STEPS   = 256,
	parameter int unsigned WORD_BITS   = 64,
	localparam int unsigned WPS    = (MAX_STEPS + WORD_BITS - 1) / WORD_BITS,
	localparam int unsigned WDEPTH = MAX_SAMPLES * WPS,
	localparam int unsigned WA_W   = (WDEPTH > 1) ? $clog2(WDEPTH) : 1,
	localparam int unsigned SA_W   = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1,
	localparam int unsigned FA_W   = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  vba_pkg::vba_mem_ctl_t      ctl,
	input  logic [WA_W-1:0]            word_addr,
	input  logic [SA_W-1:0]            cnt_addr,
	input  logic [FA_W-1:0]            flag_addr,
	input  logic [WORD_BITS-1:0]       word_wdata,
	input  logic [vba_pkg::CNT_W-1:0]  cnt_wdata,
	input  logic                       flag_wdata,
	output logic [WORD_BITS-1:0]       word_rdata,
	output logic [vba_pkg::CNT_W-1:0]  cnt_rdata,
	output logic                       flag_rdata,
	output logic                       clr_busy
);
	import vba_pkg::*;

	localparam int unsigned CLR_N = (WDEPTH > MAX_STEPS) ? WDEPTH : MAX_STEPS;
	localparam int unsigned CLR_W = $clog2(CLR_N + 1);

	logic [WORD_BITS-1:0] word_mem [WDEPTH];
	logic [CNT_W-1:0]     cnt_mem  [MAX_SAMPLES];
	logic                 flag_mem [MAX_STEPS];

	logic [WA_W-1:0]      word_addr_q;
	logic [SA_W-1:0]      cnt_addr_q;
	logic [FA_W-1:0]      flag_addr_q;
	logic [WORD_BITS-1:0] word_rdata_q;
	logic [CNT_W-1:0]     cnt_rdata_q;
	logic                 flag_rdata_q;
	logic [CLR_W-1:0]     clr_cnt_q;
	logic                 clr_busy_q;

	// sweep starts out of reset and again on every register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (ctl.clr) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clr_busy_q) begin
			clr_cnt_q <= clr_cnt_q + CLR_W'(1);
			if (clr_cnt_q == CLR_W'(CLR_N - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			if (clr_cnt_q < CLR_W'(WDEPTH)) begin
				word_mem[clr_cnt_q[WA_W-1:0]] <= '0;
			end
			if (clr_cnt_q < CLR_W'(MAX_SAMPLES)) begin
				cnt_mem[clr_cnt_q[SA_W-1:0]] <= '0;
			end
			if (clr_cnt_q < CLR_W'(MAX_STEPS)) begin
				flag_mem[clr_cnt_q[FA_W-1:0]] <= 1'b0;
			end
		end else if (ctl.wr) begin
			word_mem[word_addr_q] <= word_wdata;
			cnt_mem[cnt_addr_q]   <= cnt_wdata;
			flag_mem[flag_addr_q] <= flag_wdata;
		end
		if (ctl.rd) begin
			word_addr_q  <= word_addr;
			cnt_addr_q   <= cnt_addr;
			flag_addr_q  <= flag_addr;
			word_rdata_q <= word_mem[word_addr];
			cnt_rdata_q  <= cnt_mem[cnt_addr];
			flag_rdata_q <= flag_mem[flag_addr];
		end
	end

	assign word_rdata = word_rdata_q;
	assign cnt_rdata  = cnt_rdata_q;
	assign flag_rdata = flag_rdata_q;
	assign clr_busy   = clr_busy_q;

endmodule

`default_nettype wire

/* rtl/core/vba_checker.sv */
// Port-level checker for the accumulator core, bound into the core module.
`default_nettype none

`include "assert_macros.svh"

module vba_checker (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      cfg_valid,
	input wire logic                      cfg_ready,
	input wire logic                      req_valid,
	input wire logic                      req_stall,
	input wire logic                      rsp_valid,
	input wire logic                      rsp_stall,
	input wire logic                      lit,
	input wire logic [vba_pkg::CNT_W-1:0] lit_steps,
	input wire logic                      step_done,
	input wire logic                      error
);

	`VBA_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid, "stalled result dropped")
	`VBA_ASSERT_NEXT(a_one_item, req_valid && !req_stall, req_stall, "item taken while busy")
	`VBA_ASSERT_NEXT(a_cfg_clear, cfg_valid && cfg_ready, req_stall, "no clearing pass on write")
	`VBA_ASSERT(a_err_zero, rsp_valid && error |-> !lit && lit_steps == '0 && !step_done, "error result not zero")
	`VBA_ASSERT(a_lit_count, rsp_valid && !error && lit |-> lit_steps != '0, "lit bit with zero count")

endmodule

bind visibility_bitmap_accumulator_core vba_checker u_vba_checker (.*);

`default_nettype wire

/* sim/visibility_bitmap_accumulator_core_test.sv */
// Self-checking testbench for the visibility bitmap accumulator core.
`timescale 1ns / 1ps

module visibility_bitmap_accumulator_core_test;
	import vba_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned IDLE_PCT    = 23;

	typedef struct {
		logic                     op;
		logic [SMP_IDX_W-1:0]     smp;
		logic [STP_IDX_W-1:0]     stp;
		logic signed [COMP_W-1:0] nx, ny, nz;
		logic                     has_n;
		logic signed [COMP_W-1:0] sx, sy, sz;
		logic                     blk;
		logic                     last;
	} sun_item_t;

	typedef struct {
		logic             lit;
		logic [CNT_W-1:0] lit_steps;
		logic             step_done;
		logic [CNT_W-1:0] resolved_total;
		logic             error;
	} view_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic req_valid = 1'b0;
	logic req_stall;
	logic op = OP_RECORD;
	logic [SMP_IDX_W-1:0] sample_index = '0;
	logic [STP_IDX_W-1:0] step_index = '0;
	logic signed [COMP_W-1:0] normal_x = '0, normal_y = '0, normal_z = '0;
	logic has_normal = 1'b0;
	logic signed [COMP_W-1:0] sun_x = '0, sun_y = '0, sun_z = '0;
	logic blocked = 1'b0;
	logic last_of_step = 1'b0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	logic lit;
	logic [CNT_W-1:0] lit_steps;
	logic step_done;
	logic [CNT_W-1:0] resolved_total;
	logic error;

	visibility_bitmap_accumulator_core dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req_valid(req_valid), .req_stall(req_stall), .op(op),
		.sample_index(sample_index), .step_index(step_index),
		.normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
		.has_normal(has_normal), .sun_x(sun_x), .sun_y(sun_y), .sun_z(sun_z),
		.blocked(blocked), .last_of_step(last_of_step),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .lit(lit),
		.lit_steps(lit_steps), .step_done(step_done),
		.resolved_total(resolved_total), .error(error)
	);

	// predicted accumulator state
	bit [STEP_IDX_N-1:0] lit_rows [1024];
	int unsigned lit_tally_of [1024];
	bit [STEP_IDX_N-1:0] resolved_steps;
	int unsigned resolved_sum;
	int unsigned cfg_samples, cfg_steps;

	sun_item_t pending_q[$];
	view_t expected_views[$];
	sun_item_t drv_item;
	int unsigned pushed_cnt, accepted_cnt, results_cnt, settings_cnt;
	int unsigned fail_cnt, cycle_cnt;
	bit calm;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic void clear_model();
		for (int i = 0; i < 1024; i++) begin
			lit_rows[i] = '0;
			lit_tally_of[i] = 0;
		end
		resolved_steps = '0;
		resolved_sum = 0;
	endfunction

	function automatic void apply_observation(sun_item_t it);
		view_t v;
		int unsigned smp_lim, stp_lim;
		longint dot;
		bit cur, facing, nb;
		smp_lim = (cfg_samples < 1024) ? cfg_samples : 1024;
		stp_lim = (cfg_steps < STEP_IDX_N) ? cfg_steps : STEP_IDX_N;
		if (it.smp >= smp_lim || it.stp >= stp_lim) begin
			v = '{1'b0, '0, 1'b0, resolved_sum[CNT_W-1:0], 1'b1};
		end else begin
			cur = lit_rows[it.smp][it.stp];
			if (it.op == OP_RECORD) begin
				facing = 1'b1;
				if (it.has_n) begin
					dot = longint'(it.nx) * longint'(it.sx) + longint'(it.ny) * longint'(it.sy)
						+ longint'(it.nz) * longint'(it.sz);
					facing = dot > 0;
				end
				nb = facing && !it.blk;
				if (nb && !cur)
					lit_tally_of[it.smp]++;
				else if (!nb && cur)
					lit_tally_of[it.smp]--;
				lit_rows[it.smp][it.stp] = nb;
				cur = nb;
				if (it.last && !resolved_steps[it.stp]) begin
					resolved_steps[it.stp] = 1'b1;
					resolved_sum++;
				end
			end
			v.lit = cur;
			v.lit_steps = lit_tally_of[it.smp][CNT_W-1:0];
			v.step_done = resolved_steps[it.stp];
			v.resolved_total = resolved_sum[CNT_W-1:0];
			v.error = 1'b0;
		end
		expected_views = {expected_views, v};
	endfunction

	// request side: one item held until taken, random gaps between items
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			if (req_valid && !req_stall) begin
				apply_observation(drv_item);
				accepted_cnt++;
			end
			if (!req_valid || !req_stall) begin
				if (pending_q.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
					drv_item = pending_q.pop_front();
					req_valid <= 1'b1;
					op <= drv_item.op;
					sample_index <= drv_item.smp;
					step_index <= drv_item.stp;
					normal_x <= drv_item.nx;
					normal_y <= drv_item.ny;
					normal_z <= drv_item.nz;
					has_normal <= drv_item.has_n;
					sun_x <= drv_item.sx;
					sun_y <= drv_item.sy;
					sun_z <= drv_item.sz;
					blocked <= drv_item.blk;
					last_of_step <= drv_item.last;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string name, input int unsigned exp_v,
		input int unsigned act_v);
		if (exp_v != act_v) begin
			fail_cnt++;
			if (fail_cnt <= 10)
				$display("[%0t] %s mismatch: expected %0d, got %0d", $time, name, exp_v, act_v);
		end
	endtask

	// response side: random stall, compare against the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		view_t e;
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				results_cnt++;
				if (expected_views.size() == 0) begin
					fail_cnt++;
					if (fail_cnt <= 10)
						$display("[%0t] result arrived with none outstanding", $time);
				end else begin
					e = expected_views.pop_front();
					check_field("lit", 32'(e.lit), 32'(lit));
					check_field("lit_steps", 32'(e.lit_steps), 32'(lit_steps));
					check_field("step_done", 32'(e.step_done), 32'(step_done));
					check_field("resolved_total", 32'(e.resolved_total),
						32'(resolved_total));
					check_field("error", 32'(e.error), 32'(error));
				end
			end
			rsp_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding", cycle_cnt,
				expected_views.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic sun_item_t mk(input logic o, input int unsigned s, input int unsigned t,
		input int nx, input int ny, input int nz, input logic hn,
		input int sx, input int sy, input int sz, input logic b, input logic l);
		sun_item_t it;
		it.op = o;
		it.smp = s[SMP_IDX_W-1:0];
		it.stp = t[STP_IDX_W-1:0];
		it.nx = nx[COMP_W-1:0];
		it.ny = ny[COMP_W-1:0];
		it.nz = nz[COMP_W-1:0];
		it.has_n = hn;
		it.sx = sx[COMP_W-1:0];
		it.sy = sy[COMP_W-1:0];
		it.sz = sz[COMP_W-1:0];
		it.blk = b;
		it.last = l;
		return it;
	endfunction

	function automatic int rand_comp();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 10) return -32768;
		if (r < 20) return 32767;
		if (r < 25) return 0;
		return $urandom_range(0, 65535) - 32768;
	endfunction

	// mostly in-range indexes on a few hot samples so the counts build up
	function automatic sun_item_t rand_item();
		sun_item_t it;
		int unsigned smp_lim, stp_lim, r;
		smp_lim = (cfg_samples < 1024) ? cfg_samples : 1024;
		stp_lim = (cfg_steps < STEP_IDX_N) ? cfg_steps : STEP_IDX_N;
		it = mk(($urandom_range(0, 99) < 20) ? OP_QUERY : OP_RECORD, 0, 0,
			rand_comp(), rand_comp(), rand_comp(), $urandom_range(0, 99) < 75,
			rand_comp(), rand_comp(), rand_comp(), $urandom_range(0, 99) < 30,
			$urandom_range(0, 99) < 15);
		r = $urandom_range(0, 99);
		if (r < 8 || smp_lim == 0)
			it.smp = SMP_IDX_W'($urandom);
		else if (r < 60)
			it.smp = SMP_IDX_W'($urandom_range(0, ((smp_lim < 6) ? smp_lim : 6) - 1));
		else
			it.smp = SMP_IDX_W'($urandom_range(0, smp_lim - 1));
		if ($urandom_range(0, 99) < 8 || stp_lim == 0)
			it.stp = STP_IDX_W'($urandom);
		else
			it.stp = STP_IDX_W'($urandom_range(0, stp_lim - 1));
		return it;
	endfunction

	task automatic enqueue(input sun_item_t it);
		pending_q = {pending_q, it};
		pushed_cnt++;
	endtask

	task automatic enqueue_random(input int unsigned n);
		repeat (n) enqueue(rand_item());
	endtask

	task automatic wait_idle();
		while (accepted_cnt != pushed_cnt || expected_views.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[CFG_DATA_W-1:0];
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == REG_SAMPLE_COUNT)
			cfg_samples = val & 32'h7FF;
		else
			cfg_steps = val & 32'h1FF;
		clear_model();
		settings_cnt++;
	endtask

	initial begin
		clear_model();
		cfg_samples = 0;
		cfg_steps = 0;
		calm = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// both counts zero after reset: everything is out of range
		enqueue(mk(OP_RECORD, 0, 0, 0, 0, 0, 1'b0, 0, 0, 0, 1'b0, 1'b1));
		enqueue(mk(OP_QUERY, 0, 0, 0, 0, 0, 1'b0, 0, 0, 0, 1'b0, 1'b0));
		enqueue(mk(OP_RECORD, 1023, 255, 0, 0, 0, 1'b0, 0, 0, 0, 1'b0, 1'b1));
		wait_idle();

		write_reg(REG_SAMPLE_COUNT, 4);
		write_reg(REG_STEP_COUNT, 3);
		enqueue(mk(OP_RECORD, 0, 0, 0, 0, 0, 1'b0, 0, 0, 0, 1'b0, 1'b0));
		enqueue(mk(OP_RECORD, 0, 0, 0, 0, 0, 1'b0, 0, 0, 0, 1'b1, 1'b0));
		enqueue(mk(OP_RECORD, 0, 1, -32768, 0, 0, 1'b1, -32768, 0, 0, 1'b0, 1'b1));
		// resolving the same step again leaves flag and total alone
		enqueue(mk(OP_RECORD, 0, 1, -32768, 0, 0, 1'b1, -32768, 0, 0, 1'b0, 1'b1));
		// dot product exactly zero faces away
		enqueue(mk(OP_RECORD, 1, 2, 32767, 0, 0, 1'b1, 0, 32767, 0, 1'b0, 1'b0));
		enqueue(mk(OP_RECORD, 1, 2, -32768, 32767, 0, 1'b1, 32767, 32767, 0, 1'b0, 1'b0));
		// largest positive sum, beyond 32 bits signed
		enqueue(mk(OP_RECORD, 3, 2, -32768, -32768, -32768, 1'b1,
			-32768, -32768, -32768, 1'b0, 1'b1));
		enqueue(mk(OP_RECORD, 3, 0, 32767, 32767, 32767, 1'b1,
			-32768, -32768, -32768, 1'b0, 1'b0));
		enqueue(mk(OP_RECORD, 3, 1, 0, 0, 0, 1'b0, 0, 0, 0, 1'b1, 1'b0));
		enqueue(mk(OP_QUERY, 0, 1, 5, 5, 5, 1'b1, -5, -5, -5, 1'b1, 1'b1));
		enqueue(mk(OP_QUERY, 2, 0, 0, 0, 0, 1'b0, 0, 0, 0, 1'b0, 1'b0));
		enqueue(mk(OP_RECORD, 4, 0, 0, 0, 0, 1'b0, 0, 0, 0, 1'b0, 1'b1));
		enqueue(mk(OP_RECORD, 0, 3, 0, 0, 0, 1'b0, 0, 0, 0, 1'b0, 1'b1));
		enqueue(mk(OP_QUERY, 1023, 255, 0, 0, 0, 1'b0, 0, 0, 0, 1'b0, 1'b0));
		enqueue(mk(OP_RECORD, 3, 2, 1, 0, 0, 1'b1, 1, 0, 0, 1'b0, 1'b0));
		enqueue(mk(OP_RECORD, 2, 0, 0, 0, -32768, 1'b1, 0, 0, -1, 1'b0, 1'b0));
		enqueue(mk(OP_RECORD, 2, 0, 0, 0, 0, 1'b0, 0, 0, 0, 1'b1, 1'b0));
		wait_idle();

		// full size: light one sample on every step and resolve all steps
		write_reg(REG_STEP_COUNT, 256);
		write_reg(REG_SAMPLE_COUNT, 1024);
		for (int t = 0; t < 256; t++)
			enqueue(mk(OP_RECORD, 1023, t, rand_comp(), rand_comp(), rand_comp(), 1'b0,
				rand_comp(), rand_comp(), rand_comp(), 1'b0, 1'b1));
		enqueue_random(70);
		wait_idle();
		calm = 1'b1;
		enqueue_random(80);
		wait_idle();
		calm = 1'b0;

		write_reg(REG_SAMPLE_COUNT, 1);
		write_reg(REG_STEP_COUNT, 1);
		enqueue_random(60);
		wait_idle();

		// steps cross a bitmap word boundary
		write_reg(REG_SAMPLE_COUNT, 700);
		write_reg(REG_STEP_COUNT, 70);
		enqueue_random(200);
		wait_idle();

		write_reg(REG_SAMPLE_COUNT, 0);
		enqueue_random(10);
		wait_idle();

		write_reg(REG_SAMPLE_COUNT, 5);
		write_reg(REG_STEP_COUNT, 0);
		enqueue_random(10);
		wait_idle();

		$display("Covered %0d items and %0d results across %0d register writes,",
			accepted_cnt, results_cnt, settings_cnt);
		$display("with both counts at zero, one and full size; %0d mismatches", fail_cnt);
		if (fail_cnt == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
